// File: hw/rtl/tbgc_pkg.sv
// shared types, codes and constants for the two-button gesture classifier
package tbgc_pkg;

  localparam int CFG_WIDTH          = 24;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int IN_TIME_WIDTH      = 48;
  localparam int TIME_WIDTH_DEFAULT = 48;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TIME  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_LIMIT      = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTH_HOLD_TIME = 2'd2;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TIME_RESET  = 24'd30000;
  localparam logic [CFG_WIDTH-1:0] TAP_LIMIT_RESET      = 24'd3000000;
  localparam logic [CFG_WIDTH-1:0] BOTH_HOLD_TIME_RESET = 24'd5000000;

  localparam logic REQ_EDGE      = 1'b0;
  localparam logic REQ_CHECK     = 1'b1;
  localparam logic BUTTON_A      = 1'b0;
  localparam logic BUTTON_B      = 1'b1;
  localparam logic LEVEL_PRESSED = 1'b0;

  typedef enum logic [1:0] {
    GEST_TAP_A   = 2'd0,
    GEST_TAP_B   = 2'd1,
    GEST_LONG_B  = 2'd2,
    GEST_LONG_AB = 2'd3
  } gesture_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] tap_limit;
    logic [CFG_WIDTH-1:0] both_hold_time;
  } cfg_t;

  typedef struct packed {
    logic                     req_type;
    logic                     button;
    logic                     level;
    logic [IN_TIME_WIDTH-1:0] time_us;
  } item_t;

endpackage

// File: hw/rtl/tbgc_ifs.sv
// valid/ready channel interfaces for edge/check items and gesture results
interface tbgc_in_if;
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic                               button;
  logic                               level;
  logic [tbgc_pkg::IN_TIME_WIDTH-1:0] time_us;

  modport source (output valid, req_type, button, level, time_us, input ready);
  modport sink   (input valid, req_type, button, level, time_us, output ready);
endinterface

interface tbgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

// File: hw/rtl/tbgc_cfg_regs.sv
// configuration register bank written through the plain write port
module tbgc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [tbgc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tbgc_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  output tbgc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time  <= tbgc_pkg::DEBOUNCE_TIME_RESET;
      cfg.tap_limit      <= tbgc_pkg::TAP_LIMIT_RESET;
      cfg.both_hold_time <= tbgc_pkg::BOTH_HOLD_TIME_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == tbgc_pkg::REG_DEBOUNCE_TIME) begin
        cfg.debounce_time <= cfg_wdata;
      end
      if (cfg_index == tbgc_pkg::REG_TAP_LIMIT) begin
        cfg.tap_limit <= cfg_wdata;
      end
      if (cfg_index == tbgc_pkg::REG_BOTH_HOLD_TIME) begin
        cfg.both_hold_time <= cfg_wdata;
      end
    end
  end

endmodule

// File: hw/rtl/tbgc_classify.sv
// per-button debounce and press state with the combinational gesture decision
module tbgc_classify #(
  parameter int TIME_WIDTH = tbgc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  tbgc_pkg::item_t    item,
  input  tbgc_pkg::cfg_t     cfg,
  output logic               res_valid,
  output tbgc_pkg::gesture_t res_gesture
);

  logic [TIME_WIDTH-1:0] last_edge      [2];
  logic [TIME_WIDTH-1:0] last_edge_next [2];
  logic [TIME_WIDTH-1:0] press_start      [2];
  logic [TIME_WIDTH-1:0] press_start_next [2];
  logic [1:0]            is_held;
  logic [1:0]            is_held_next;
  logic [1:0]            long_consumed;
  logic [1:0]            long_consumed_next;

  logic [TIME_WIDTH-1:0] t;
  logic                  b;
  logic [TIME_WIDTH-1:0] since_edge;
  logic [TIME_WIDTH-1:0] held_for [2];
  logic [TIME_WIDTH-1:0] both_held_for;
  logic [TIME_WIDTH-1:0] debounce_time;
  logic [TIME_WIDTH-1:0] tap_limit;
  logic [TIME_WIDTH-1:0] both_hold_time;

  assign t              = TIME_WIDTH'(item.time_us);
  assign b              = item.button;
  assign debounce_time  = TIME_WIDTH'(cfg.debounce_time);
  assign tap_limit      = TIME_WIDTH'(cfg.tap_limit);
  assign both_hold_time = TIME_WIDTH'(cfg.both_hold_time);

  // all differences wrap modulo 2^TIME_WIDTH
  assign since_edge  = t - last_edge[b];
  assign held_for[0] = t - press_start[0];
  assign held_for[1] = t - press_start[1];
  // time since the later press
  assign both_held_for = (press_start[0] > press_start[1]) ? held_for[0] : held_for[1];

  always_comb begin
    last_edge_next     = last_edge;
    press_start_next   = press_start;
    is_held_next       = is_held;
    long_consumed_next = long_consumed;
    res_valid          = 1'b0;
    res_gesture        = tbgc_pkg::GEST_TAP_A;
    if (step) begin
      if (item.req_type == tbgc_pkg::REQ_CHECK) begin
        if (is_held[0] && is_held[1] && !long_consumed[0]
            && (both_held_for >= both_hold_time)) begin
          long_consumed_next = 2'b11;
          res_valid          = 1'b1;
          res_gesture        = tbgc_pkg::GEST_LONG_AB;
        end
      end else if (since_edge >= debounce_time) begin
        last_edge_next[b] = t;
        if (item.level == tbgc_pkg::LEVEL_PRESSED) begin
          if (!is_held[b]) begin
            is_held_next[b]     = 1'b1;
            press_start_next[b] = t;
          end
        end else if (is_held[b]) begin
          is_held_next[b] = 1'b0;
          if (long_consumed[b]) begin
            // release after long-AB is swallowed
            long_consumed_next[b] = 1'b0;
          end else if (held_for[b] < tap_limit) begin
            res_valid   = 1'b1;
            res_gesture = (b == tbgc_pkg::BUTTON_B) ? tbgc_pkg::GEST_TAP_B
                                                    : tbgc_pkg::GEST_TAP_A;
          end else if (b == tbgc_pkg::BUTTON_B) begin
            res_valid   = 1'b1;
            res_gesture = tbgc_pkg::GEST_LONG_B;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge[0]   <= '0;
      last_edge[1]   <= '0;
      press_start[0] <= '0;
      press_start[1] <= '0;
      is_held        <= '0;
      long_consumed  <= '0;
    end else begin
      last_edge     <= last_edge_next;
      press_start   <= press_start_next;
      is_held       <= is_held_next;
      long_consumed <= long_consumed_next;
    end
  end

endmodule

// File: hw/rtl/two_button_gesture_classifier_core.sv
// top level of the two-button gesture classifier
//
//   channel   dir  handshake      payload
//   item_in   in   valid/ready    req_type, button, level, time_us
//   item_out  out  valid/ready    gesture
//   cfg       in   cfg_wr_en      cfg_index, cfg_wdata
//
// one item per cycle while the result register is not stalled; the input register
// loads at the accepting edge and the decision logic loads the result register from
// it on a step, and the result is offered from the result register
// reset clears button state and loads the default timing registers
// a stalled result holds the input register; item_in.ready falls only then
module two_button_gesture_classifier_core #(
  parameter int TIME_WIDTH = tbgc_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [tbgc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [tbgc_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  tbgc_in_if.sink                              item_in,
  tbgc_out_if.source                           item_out
);

  tbgc_pkg::cfg_t     cfg;
  tbgc_pkg::item_t    item_q;
  logic               item_valid;
  logic               step;
  logic               res_valid;
  tbgc_pkg::gesture_t res_gesture;
  logic               out_valid;
  tbgc_pkg::gesture_t out_gesture;

  assign step          = item_valid && (!out_valid || item_out.ready);
  assign item_in.ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_in.ready) begin
      item_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.ready && item_in.valid) begin
      item_q.req_type <= item_in.req_type;
      item_q.button   <= item_in.button;
      item_q.level    <= item_in.level;
      item_q.time_us  <= item_in.time_us;
    end
  end

  tbgc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tbgc_classify #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_classify (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item_q),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res_gesture (res_gesture)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (item_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_gesture <= res_gesture;
    end
  end

  assign item_out.valid   = out_valid;
  assign item_out.gesture = out_gesture;

endmodule
